// ===== hw/rtl/prf_pkg.sv =====
// Shared types, constants and predictor functions of the PNG row filter.
`timescale 1ns / 1ps
package prf_pkg;

  localparam int MAX_ROW_BYTES_DEF   = 8192;
  localparam int MAX_PIXEL_BYTES_DEF = 8;
  localparam int NUM_FILT            = 5;
  localparam int COST_W              = 21;
  // op word width without its two position fields
  localparam int OP_FIXED_W          = 16;
  localparam int OP_FIFO_DEPTH       = 4;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  localparam logic [2:0] MODE_NONE     = 3'd0;
  localparam logic [2:0] MODE_ADAPTIVE = 3'd5;

  localparam logic [1:0] CFG_FILTER_MODE     = 2'd0;
  localparam logic [1:0] CFG_BYTES_PER_PIXEL = 2'd1;
  localparam logic [1:0] CFG_ROW_BYTES       = 2'd2;

  // current byte and its left, upper and upper-left neighbors
  typedef struct packed {
    logic [7:0] x;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
  } nbr_t;

  // row store word: the byte and the byte above it
  typedef struct packed {
    logic [7:0] above;
    logic [7:0] pix;
  } word_t;

  function automatic logic signed [10:0] abs11(input logic signed [10:0] v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [7:0] residual(input filt_t f, input nbr_t n);
    logic signed [10:0] sa;
    logic signed [10:0] sb;
    logic signed [10:0] sc;
    logic signed [10:0] pa;
    logic signed [10:0] pb;
    logic signed [10:0] pc;
    logic [8:0]         avg_sum;
    logic [7:0]         pred;
    sa      = $signed({3'b000, n.a});
    sb      = $signed({3'b000, n.b});
    sc      = $signed({3'b000, n.c});
    pa      = abs11(sb - sc);
    pb      = abs11(sa - sc);
    pc      = abs11(sa + sb - sc - sc);
    avg_sum = {1'b0, n.a} + {1'b0, n.b};
    case (f)
      FILT_NONE: pred = '0;
      FILT_SUB:  pred = n.a;
      FILT_UP:   pred = n.b;
      FILT_AVG:  pred = avg_sum[8:1];
      FILT_PAETH: begin
        if (pa <= pb && pa <= pc) pred = n.a;
        else if (pb <= pc)        pred = n.b;
        else                      pred = n.c;
      end
      default:   pred = '0;
    endcase
    return n.x - pred;
  endfunction

  // |r| with r read as a signed byte
  function automatic logic [7:0] magnitude(input logic [7:0] r);
    return r[7] ? 8'(-r) : r;
  endfunction

endpackage

// ===== hw/rtl/prf_ram.sv =====
// Generic simple dual-read RAM, registered read, write-through on collision.
`timescale 1ns / 1ps
module prf_ram #(
  parameter int Width = 16,
  parameter int Depth = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr_a,
  input  logic [$clog2(Depth)-1:0] raddr_b,
  output logic [Width-1:0]         rdata_a,
  output logic [Width-1:0]         rdata_b
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
      rdata_b <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
    end
  end

endmodule

// ===== hw/rtl/prf_fifo.sv =====
// Small op queue between the front and back parts.
`timescale 1ns / 1ps
module prf_fifo #(
  parameter int Width = 16,
  parameter int Depth = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [Width-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [Width-1:0] dout,
  output logic             empty
);

  localparam int PtrW = $clog2(Depth);

  logic [Width-1:0] slot_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PtrW:0]    count_r, count_nxt;

  assign full  = (count_r == (PtrW+1)'(Depth));
  assign empty = (count_r == '0);
  assign dout  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PtrW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PtrW'(1) : rd_ptr_r;
    count_nxt  = count_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== hw/rtl/prf_front.sv =====
// Front part: accepts beats, tracks row positions and issues ops to the queue.
`timescale 1ns / 1ps
module prf_front #(
  parameter int PosW  = 13,
  parameter int RlenW = 14
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,
  input  logic [1:0]                           in_tuser,
  input  logic [RlenW-1:0]                     rlen,
  input  logic                                 fifo_full,
  output logic                                 push,
  output logic [prf_pkg::OP_FIXED_W+2*PosW-1:0] op_data
);

  typedef struct packed {
    logic            emit_vld;
    logic            emit_first;
    logic            emit_last;
    logic [PosW-1:0] emit_idx;
    logic            ing_vld;
    logic            ing_first;
    logic [7:0]      ing_byte;
    logic [PosW-1:0] ing_pos;
    logic            row_done;
    logic            no_above;
    logic            inc_bank;
  } op_t;

  logic [PosW-1:0]  wp_r, wp_nxt;
  logic [RlenW-1:0] epos_r, epos_nxt;
  logic             pend_r, pend_nxt;
  logic             noabove_r, noabove_nxt;
  logic             bank_r, bank_nxt;
  logic             accept;
  logic [PosW-1:0]  idx;
  logic [RlenW-1:0] wp_inc;
  op_t              op;

  assign in_tready = !fifo_full;
  assign accept    = in_tvalid && in_tready;
  assign push      = accept;
  assign op_data   = op;

  always_comb begin
    wp_nxt      = wp_r;
    epos_nxt    = epos_r;
    pend_nxt    = pend_r;
    noabove_nxt = noabove_r;
    bank_nxt    = bank_r;
    op          = '0;
    idx         = (epos_r == '0) ? '0 : PosW'(epos_r - RlenW'(1));
    wp_inc      = RlenW'(wp_r) + RlenW'(1);
    op.inc_bank = bank_r;
    if (accept) begin
      // emit side of the pending row comes first
      if (pend_r) begin
        op.emit_vld   = 1'b1;
        op.emit_first = (epos_r == '0);
        op.emit_idx   = idx;
        op.emit_last  = (RlenW'(idx) + RlenW'(1) >= rlen);
        if (op.emit_last) begin
          pend_nxt = 1'b0;
          epos_nxt = '0;
        end else begin
          epos_nxt = RlenW'(idx) + RlenW'(2);
        end
      end
      // pixel beat: store side of the incoming row
      if (!in_tuser[0]) begin
        op.ing_vld   = 1'b1;
        op.ing_first = (wp_r == '0);
        op.ing_byte  = in_tdata;
        op.ing_pos   = wp_r;
        if (wp_r == '0) begin
          noabove_nxt = in_tuser[1];
        end
        if (wp_inc >= rlen) begin
          op.row_done = 1'b1;
          op.no_above = noabove_nxt;
          pend_nxt    = 1'b1;
          epos_nxt    = '0;
          bank_nxt    = !bank_r;
          wp_nxt      = '0;
        end else begin
          wp_nxt = PosW'(wp_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      epos_r    <= '0;
      pend_r    <= 1'b0;
      noabove_r <= 1'b0;
      bank_r    <= 1'b0;
    end else begin
      wp_r      <= wp_nxt;
      epos_r    <= epos_nxt;
      pend_r    <= pend_nxt;
      noabove_r <= noabove_nxt;
      bank_r    <= bank_nxt;
    end
  end

endmodule

// ===== hw/rtl/prf_back.sv =====
// Back part: row stores, predictors, cost accumulation, filter pick, output stage.
`timescale 1ns / 1ps
module prf_back #(
  parameter int MaxRowBytes   = 8192,
  parameter int MaxPixelBytes = 8,
  parameter int PosW          = 13
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 fifo_empty,
  output logic                                 pop,
  input  logic [prf_pkg::OP_FIXED_W+2*PosW-1:0] op_data,
  input  logic [2:0]                           mode,
  input  logic [3:0]                           bpp,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [7:0]                           out_tdata,
  output logic                                 out_tuser,
  output logic                                 out_tlast
);

  localparam int CostW = prf_pkg::COST_W;
  localparam int NF    = prf_pkg::NUM_FILT;

  typedef struct packed {
    logic            emit_vld;
    logic            emit_first;
    logic            emit_last;
    logic [PosW-1:0] emit_idx;
    logic            ing_vld;
    logic            ing_first;
    logic [7:0]      ing_byte;
    logic [PosW-1:0] ing_pos;
    logic            row_done;
    logic            no_above;
    logic            inc_bank;
  } op_t;

  typedef struct packed {
    logic          emit_vld;
    logic          emit_first;
    logic          emit_last;
    logic          ing_vld;
    logic          ing_first;
    logic          row_done;
    logic          no_above;
    prf_pkg::nbr_t en;
  } ctl_t;

  op_t                  head;
  logic                 adv;
  logic                 wr_en;
  prf_pkg::word_t       wr_word;
  logic [15:0]          rd_a [2];
  logic [15:0]          rd_b [2];
  prf_pkg::word_t       word_a, word_b;

  // stage 1: store data back
  logic                 s1_vld_r;
  op_t                  s1_r;
  logic [7:0]           a_line_r [MaxPixelBytes];
  logic [7:0]           c_line_r [MaxPixelBytes];
  prf_pkg::word_t       e_line_r [MaxPixelBytes];
  logic [7:0]           a_sel, c_sel;
  prf_pkg::word_t       e_sel;
  logic                 ing_left, emit_left;
  prf_pkg::nbr_t        ing_n;
  ctl_t                 s1_ctl;
  logic [7:0]           mag [NF];

  // stage 2: cost accumulation
  logic                 s2_vld_r;
  ctl_t                 s2_r;
  logic [7:0]           s2_mag_r [NF];
  logic [CostW-1:0]     costs_r [NF];

  // stage 3: pairwise compare
  logic                 s3_vld_r;
  ctl_t                 s3_r;
  logic [CostW:0]       cv [NF];

  // stage 4: pick and emitted residual
  logic                 s4_vld_r;
  ctl_t                 s4_r;
  prf_pkg::filt_t       s4_w01_idx_r, s4_w23_idx_r;
  logic [CostW:0]       s4_w01_val_r, s4_w23_val_r, s4_v4_r;
  prf_pkg::filt_t       chosen_r;
  prf_pkg::filt_t       pick;
  prf_pkg::filt_t       tree_idx;
  logic [CostW:0]       tree_val;

  // output stage: up to two beats
  logic                 o_code_vld_r, o_res_vld_r;
  logic [7:0]           o_code_r, o_res_r;
  logic                 o_last_r;

  assign head = op_t'(op_data);
  assign adv  = !(o_code_vld_r || o_res_vld_r) ||
                (out_tready && (o_code_vld_r != o_res_vld_r));
  assign pop  = adv && !fifo_empty;

  assign wr_en   = adv && s1_vld_r && s1_r.ing_vld;
  assign word_a  = prf_pkg::word_t'(rd_a[!s1_r.inc_bank]);
  assign word_b  = prf_pkg::word_t'(rd_b[!s1_r.inc_bank]);
  assign wr_word = '{above: word_a.pix, pix: s1_r.ing_byte};

  // ping-pong row stores: incoming row is written, pending row is read
  for (genvar k = 0; k < 2; k++) begin : g_bank
    prf_ram #(
      .Width (16),
      .Depth (MaxRowBytes)
    ) u_bank (
      .clk     (clk),
      .we      (wr_en && (s1_r.inc_bank == 1'(k))),
      .waddr   (s1_r.ing_pos),
      .wdata   (wr_word),
      .re      (adv),
      .raddr_a (head.ing_pos),
      .raddr_b (head.emit_idx),
      .rdata_a (rd_a[k]),
      .rdata_b (rd_b[k])
    );
  end

  always_comb begin
    a_sel = '0;
    c_sel = '0;
    e_sel = '0;
    for (int k = 0; k < MaxPixelBytes; k++) begin
      if ({28'b0, bpp} == 32'(k + 1)) begin
        a_sel = a_line_r[k];
        c_sel = c_line_r[k];
        e_sel = e_line_r[k];
      end
    end
  end

  always_comb begin
    ing_left  = (32'(s1_r.ing_pos) >= {28'b0, bpp});
    emit_left = (32'(s1_r.emit_idx) >= {28'b0, bpp});
    ing_n.x   = s1_r.ing_byte;
    ing_n.b   = word_a.pix;
    ing_n.a   = ing_left ? a_sel : '0;
    ing_n.c   = ing_left ? c_sel : '0;
    for (int f = 0; f < NF; f++) begin
      mag[f] = prf_pkg::magnitude(prf_pkg::residual(prf_pkg::filt_t'(3'(f)), ing_n));
    end
    s1_ctl.emit_vld   = s1_r.emit_vld;
    s1_ctl.emit_first = s1_r.emit_first;
    s1_ctl.emit_last  = s1_r.emit_last;
    s1_ctl.ing_vld    = s1_r.ing_vld;
    s1_ctl.ing_first  = s1_r.ing_first;
    s1_ctl.row_done   = s1_r.row_done;
    s1_ctl.no_above   = s1_r.no_above;
    s1_ctl.en.x       = word_b.pix;
    s1_ctl.en.b       = word_b.above;
    s1_ctl.en.a       = emit_left ? e_sel.pix : '0;
    s1_ctl.en.c       = emit_left ? e_sel.above : '0;
  end

  always_comb begin
    for (int f = 0; f < NF; f++) begin
      cv[f] = {1'b0, costs_r[f]} + (CostW+1)'(f);
    end
  end

  always_comb begin
    if (s4_w23_val_r < s4_w01_val_r) begin
      tree_idx = s4_w23_idx_r;
      tree_val = s4_w23_val_r;
    end else begin
      tree_idx = s4_w01_idx_r;
      tree_val = s4_w01_val_r;
    end
    if (s4_v4_r < tree_val) begin
      tree_idx = prf_pkg::FILT_PAETH;
    end
    if (mode == prf_pkg::MODE_NONE)           pick = prf_pkg::FILT_NONE;
    else if (s4_r.no_above)                   pick = prf_pkg::FILT_SUB;
    else if (mode < prf_pkg::MODE_ADAPTIVE)   pick = prf_pkg::filt_t'(mode);
    else                                      pick = tree_idx;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      s2_vld_r     <= 1'b0;
      s3_vld_r     <= 1'b0;
      s4_vld_r     <= 1'b0;
      chosen_r     <= prf_pkg::FILT_NONE;
      o_code_vld_r <= 1'b0;
      o_res_vld_r  <= 1'b0;
      for (int f = 0; f < NF; f++) begin
        costs_r[f] <= '0;
      end
    end else begin
      if (adv) begin
        s1_vld_r     <= !fifo_empty;
        s2_vld_r     <= s1_vld_r;
        s3_vld_r     <= s2_vld_r;
        s4_vld_r     <= s3_vld_r;
        o_code_vld_r <= s4_vld_r && s4_r.emit_vld && s4_r.emit_first;
        o_res_vld_r  <= s4_vld_r && s4_r.emit_vld;
        if (s2_vld_r && s2_r.ing_vld) begin
          for (int f = 0; f < NF; f++) begin
            costs_r[f] <= (s2_r.ing_first ? '0 : costs_r[f]) + CostW'(s2_mag_r[f]);
          end
        end
        if (s4_vld_r && s4_r.row_done) begin
          chosen_r <= pick;
        end
      end else if (out_tready && o_code_vld_r) begin
        o_code_vld_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= head;
      if (s1_vld_r && s1_r.ing_vld) begin
        a_line_r[0] <= ing_n.x;
        c_line_r[0] <= ing_n.b;
        for (int k = 1; k < MaxPixelBytes; k++) begin
          a_line_r[k] <= a_line_r[k-1];
          c_line_r[k] <= c_line_r[k-1];
        end
      end
      if (s1_vld_r && s1_r.emit_vld) begin
        e_line_r[0] <= word_b;
        for (int k = 1; k < MaxPixelBytes; k++) begin
          e_line_r[k] <= e_line_r[k-1];
        end
      end
      s2_r <= s1_ctl;
      for (int f = 0; f < NF; f++) begin
        s2_mag_r[f] <= mag[f];
      end
      s3_r <= s2_r;
      s4_r <= s3_r;
      // earliest filter wins a tie
      if (cv[1] < cv[0]) begin
        s4_w01_idx_r <= prf_pkg::FILT_SUB;
        s4_w01_val_r <= cv[1];
      end else begin
        s4_w01_idx_r <= prf_pkg::FILT_NONE;
        s4_w01_val_r <= cv[0];
      end
      if (cv[3] < cv[2]) begin
        s4_w23_idx_r <= prf_pkg::FILT_AVG;
        s4_w23_val_r <= cv[3];
      end else begin
        s4_w23_idx_r <= prf_pkg::FILT_UP;
        s4_w23_val_r <= cv[2];
      end
      s4_v4_r  <= cv[4];
      o_code_r <= {5'b0, chosen_r};
      o_res_r  <= prf_pkg::residual(chosen_r, s4_r.en);
      o_last_r <= s4_r.emit_last;
    end
  end

  assign out_tvalid = o_code_vld_r || o_res_vld_r;
  assign out_tdata  = o_code_vld_r ? o_code_r : o_res_r;
  assign out_tuser  = o_code_vld_r;
  assign out_tlast  = !o_code_vld_r && o_last_r;

endmodule

// ===== hw/rtl/png_row_filter_adaptive.sv =====
// PNG scanline filter (none/sub/up/average/Paeth, adaptive minimum sum): top level.
// Throughput: one input beat per cycle while the op queue is not full; an item that starts a
// row's output gives two beats (code and first residual), sent one after the other.
// An accepted beat passes the queue, row store read, magnitudes, cost add, pair compare and
// output register before its output beat is valid. Rows are emitted one row late.
// Reset (synchronous, active low) clears control state and costs; the row stores are not
// cleared, so the first row after reset must be flagged as having no row above.
`timescale 1ns / 1ps
module png_row_filter_adaptive #(
  parameter int MAX_ROW_BYTES   = prf_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = prf_pkg::MAX_PIXEL_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel_byte
  input  logic [1:0]  in_tuser,   // [0] action, [1] no_row_above
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tuser,  // [0] is_filter_code
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  localparam int PosW  = $clog2(MAX_ROW_BYTES);
  localparam int RlenW = $clog2(MAX_ROW_BYTES + 1);
  localparam int OpW   = prf_pkg::OP_FIXED_W + 2 * PosW;

  logic [2:0]       cfg_mode_r;
  logic [3:0]       cfg_bpp_r;
  logic [13:0]      cfg_rbytes_r;
  logic [2:0]       mode;
  logic [3:0]       bpp;
  logic [RlenW-1:0] rlen;
  logic             fifo_full, fifo_empty, push, pop;
  logic [OpW-1:0]   op_in, op_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r   <= 3'd0;
      cfg_bpp_r    <= 4'd1;
      cfg_rbytes_r <= 14'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        prf_pkg::CFG_FILTER_MODE:     cfg_mode_r   <= cfg_data[2:0];
        prf_pkg::CFG_BYTES_PER_PIXEL: cfg_bpp_r    <= cfg_data[3:0];
        prf_pkg::CFG_ROW_BYTES:       cfg_rbytes_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // out-of-range settings saturate
  always_comb begin
    mode = (cfg_mode_r > prf_pkg::MODE_ADAPTIVE) ? prf_pkg::MODE_ADAPTIVE : cfg_mode_r;
    if (cfg_bpp_r == '0)                           bpp = 4'd1;
    else if ({28'b0, cfg_bpp_r} > MAX_PIXEL_BYTES) bpp = 4'(MAX_PIXEL_BYTES);
    else                                           bpp = cfg_bpp_r;
    if (cfg_rbytes_r == '0)                           rlen = RlenW'(1);
    else if ({18'b0, cfg_rbytes_r} > MAX_ROW_BYTES)   rlen = RlenW'(MAX_ROW_BYTES);
    else                                              rlen = RlenW'(cfg_rbytes_r);
  end

  prf_front #(
    .PosW  (PosW),
    .RlenW (RlenW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .rlen      (rlen),
    .fifo_full (fifo_full),
    .push      (push),
    .op_data   (op_in)
  );

  prf_fifo #(
    .Width (OpW),
    .Depth (prf_pkg::OP_FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (op_in),
    .full  (fifo_full),
    .pop   (pop),
    .dout  (op_out),
    .empty (fifo_empty)
  );

  prf_back #(
    .MaxRowBytes   (MAX_ROW_BYTES),
    .MaxPixelBytes (MAX_PIXEL_BYTES),
    .PosW          (PosW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .pop        (pop),
    .op_data    (op_out),
    .mode       (mode),
    .bpp        (bpp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== bench/png_row_filter_adaptive_test.sv =====
// Self-checking testbench for the adaptive PNG scanline filter.
`timescale 1ns / 1ps
module png_row_filter_adaptive_test;

  localparam int ROW_MAX    = 8192;
  localparam int LONG_ROW   = 240;
  localparam int ITEM_GOAL  = 1550;
  localparam int CYCLE_CAP  = 2000000;
  localparam int SETTLE     = 20;
  localparam int ROW_STD    = 0;
  localparam int ROW_RAMP   = 1;
  localparam int ROW_FLAT   = 2;

  typedef struct {
    logic [7:0] data;
    logic       code;
    logic       last;
  } filt_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] pixel_byte
  logic [1:0]  in_tuser;   // [0] action, [1] no_row_above
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] out_byte
  logic        out_tuser;  // [0] is_filter_code
  logic        out_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [13:0] cfg_data;

  png_row_filter_adaptive u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state: three row buffers rotated by index
  logic [7:0]      rowbuf [3][ROW_MAX];
  int              inc_buf;
  int              pend_buf;
  int              abv_buf;
  logic [20:0]     row_cost [prf_pkg::NUM_FILT];
  prf_pkg::filt_t  pick_filt;
  int              wr_pos;
  int              em_pos;
  bit              pend_valid;
  bit              inc_first;
  int              cur_mode;
  int              cur_bpp;
  int              cur_len;

  filt_beat_t  filtered_q[$];
  int          errors;
  int          items_sent;
  int          cycles;
  int          burst_left;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver stall pattern: free-running, random, then mostly ready
  int stall_cnt;
  always @(negedge clk) begin
    stall_cnt <= stall_cnt + 1;
    case ((stall_cnt / 97) % 3)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 1);
      default: out_tready <= ($urandom_range(0, 4) != 0);
    endcase
  end

  task automatic report(input string what);
    $display("mismatch @%0t: %s", $time, what);
    errors++;
  endtask

  always @(posedge clk) begin
    filt_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (filtered_q.size() == 0) begin
        report($sformatf("unexpected beat %02h", out_tdata));
      end else begin
        want = filtered_q.pop_front();
        if (out_tdata !== want.data)
          report($sformatf("byte %02h, want %02h", out_tdata, want.data));
        if (out_tuser !== want.code)
          report($sformatf("code flag %b, want %b", out_tuser, want.code));
        if (out_tlast !== want.last)
          report($sformatf("last %b, want %b", out_tlast, want.last));
      end
    end
  end

  function automatic logic [7:0] filt_residual(int f, int cb, int ub, int i);
    int x, a, b, c, pa, pb, pc, pred;
    x = rowbuf[cb][i];
    b = rowbuf[ub][i];
    a = (i >= cur_bpp) ? rowbuf[cb][i - cur_bpp] : 0;
    c = (i >= cur_bpp) ? rowbuf[ub][i - cur_bpp] : 0;
    case (prf_pkg::filt_t'(f))
      prf_pkg::FILT_SUB:   pred = a;
      prf_pkg::FILT_UP:    pred = b;
      prf_pkg::FILT_AVG:   pred = (a + b) >> 1;
      prf_pkg::FILT_PAETH: begin
        pa = (b - c < 0) ? c - b : b - c;
        pb = (a - c < 0) ? c - a : a - c;
        pc = (a + b - 2 * c < 0) ? 2 * c - a - b : a + b - 2 * c;
        if (pa <= pb && pa <= pc) pred = a;
        else if (pb <= pc)        pred = b;
        else                      pred = c;
      end
      default:    pred = 0;
    endcase
    return 8'(x - pred);
  endfunction

  function automatic void filter_step(bit flush, logic [7:0] pix, bit no_above);
    int idx, best, tmp;
    bit last;
    logic [7:0] r;
    if (pend_valid) begin
      if (em_pos == 0) begin
        filtered_q.push_back('{data: 8'(pick_filt), code: 1'b1, last: 1'b0});
        em_pos = 1;
      end
      idx  = em_pos - 1;
      last = (idx + 1 >= cur_len);
      filtered_q.push_back('{data: filt_residual(pick_filt, pend_buf, abv_buf, idx),
                             code: 1'b0, last: last});
      em_pos++;
      if (last) begin
        pend_valid = 0;
        em_pos     = 0;
      end
    end
    if (!flush) begin
      if (wr_pos == 0) begin
        foreach (row_cost[f]) row_cost[f] = '0;
        inc_first = no_above;
      end
      rowbuf[inc_buf][wr_pos] = pix;
      for (int f = 0; f < prf_pkg::NUM_FILT; f++) begin
        r = filt_residual(f, inc_buf, pend_buf, wr_pos);
        row_cost[f] = row_cost[f] + (r[7] ? 21'(256 - r) : 21'(r));
      end
      wr_pos++;
      if (wr_pos >= cur_len) begin
        if (cur_mode == prf_pkg::MODE_NONE) pick_filt = prf_pkg::FILT_NONE;
        else if (inc_first)                 pick_filt = prf_pkg::FILT_SUB;
        else if (cur_mode != prf_pkg::MODE_ADAPTIVE)
          pick_filt = prf_pkg::filt_t'(cur_mode);
        else begin
          // code added to cost; strict compare keeps the earliest on a tie
          best      = row_cost[0];
          pick_filt = prf_pkg::FILT_NONE;
          for (int f = 1; f < prf_pkg::NUM_FILT; f++)
            if (row_cost[f] + f < best) begin
              best      = row_cost[f] + f;
              pick_filt = prf_pkg::filt_t'(f);
            end
        end
        tmp        = abv_buf;
        abv_buf    = pend_buf;
        pend_buf   = inc_buf;
        inc_buf    = tmp;
        pend_valid = 1;
        em_pos     = 0;
        wr_pos     = 0;
      end
    end
  endfunction

  task automatic send_beat(input bit flush, input logic [7:0] pix, input bit no_above,
                           input bit steady);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : $urandom_range(0, 5);
      repeat (gap) @(negedge clk) in_tvalid <= 1'b0;
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= {no_above, flush};
    do @(posedge clk); while (!in_tready);
    filter_step(flush, pix, no_above);
    items_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    @(negedge clk);
    in_tvalid <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 14'(value);
    @(negedge clk) cfg_we <= 1'b0;
    case (idx)
      prf_pkg::CFG_FILTER_MODE:     cur_mode = value;
      prf_pkg::CFG_BYTES_PER_PIXEL: cur_bpp  = value;
      default:                      cur_len  = value;
    endcase
  endtask

  task automatic drain;
    @(negedge clk) in_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic setup(input int mode, input int bpp, input int len);
    write_reg(prf_pkg::CFG_FILTER_MODE, mode);
    write_reg(prf_pkg::CFG_BYTES_PER_PIXEL, bpp);
    write_reg(prf_pkg::CFG_ROW_BYTES, len);
  endtask

  function automatic logic [7:0] next_pixel(int style, logic [7:0] prev);
    case (style)
      ROW_RAMP: return prev + 8'($urandom_range(0, 6)) - 8'd3;
      ROW_FLAT: return ($urandom_range(0, 7) == 0) ? 8'($urandom) : prev;
      default:  return 8'($urandom);
    endcase
  endfunction

  // one full row of pixel beats with optional flush ticks mixed in
  task automatic send_row(input bit no_above, input int style, input bit steady);
    logic [7:0] p;
    p = 8'($urandom);
    for (int i = 0; i < cur_len; i++) begin
      p = next_pixel(style, p);
      if (!steady && $urandom_range(0, 9) == 0)
        send_beat(1'b1, 8'($urandom), 1'($urandom), steady);
      send_beat(1'b0, p, (i == 0) ? no_above : 1'($urandom), steady);
    end
  endtask

  task automatic flush_out(input bit steady);
    for (int i = 0; i < cur_len; i++)
      send_beat(1'b1, 8'($urandom), 1'($urandom), steady);
  endtask

  task automatic test_directed;
    logic [7:0] pat [12] = '{8'h00, 8'hff, 8'h00, 8'hff, 8'hff, 8'h00, 8'hff, 8'h00,
                             8'h80, 8'h7f, 8'h01, 8'hfe};
    setup(prf_pkg::MODE_ADAPTIVE, 1, 4);
    for (int i = 0; i < 12; i++) begin
      // partial first row is held across a flush tick
      if (i == 2) send_beat(1'b1, 8'hff, 1'b1, 1'b1);
      send_beat(1'b0, pat[i], (i == 0), 1'b1);
    end
    flush_out(1'b1);
    drain();
    // Paeth over a wide pixel
    setup(prf_pkg::FILT_PAETH, 8, 8);
    send_row(1'b1, ROW_STD, 1'b1);
    send_row(1'b0, ROW_STD, 1'b1);
    flush_out(1'b1);
    drain();
  endtask

  task automatic test_random_phases;
    int mode, bpp, len, rows, pick;
    for (int ph = 0; items_sent < ITEM_GOAL; ph++) begin
      mode = (ph < 6) ? ph : $urandom_range(0, 5);
      pick = $urandom_range(0, 9);
      bpp  = (pick == 0) ? 1 : (pick == 1) ? 8 : $urandom_range(1, 8);
      pick = $urandom_range(0, 9);
      len  = (pick == 0) ? 1 : (pick == 1) ? 64 : $urandom_range(2, 24);
      setup(mode, bpp, len);
      rows = $urandom_range(2, 6);
      // a new setting starts with a first-of-image row
      for (int r = 0; r < rows; r++)
        send_row((r == 0) || ($urandom_range(0, 9) == 0), $urandom_range(0, 2),
                 (ph % 4) == 3);
      flush_out((ph % 4) == 3);
      drain();
    end
  endtask

  task automatic test_long_rows;
    setup(prf_pkg::MODE_ADAPTIVE, 8, LONG_ROW);
    send_row(1'b1, ROW_RAMP, 1'b1);
    send_row(1'b0, ROW_RAMP, 1'b1);
    flush_out(1'b1);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    items_sent = 0;
    cycles = 0;
    stall_cnt = 0;
    burst_left = 0;
    inc_buf = 0;
    pend_buf = 1;
    abv_buf = 2;
    foreach (row_cost[f]) row_cost[f] = '0;
    pick_filt = prf_pkg::FILT_NONE;
    wr_pos = 0;
    em_pos = 0;
    pend_valid = 0;
    inc_first = 0;
    cur_mode = 0;
    cur_bpp = 1;
    cur_len = 1;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_long_rows();
    test_random_phases();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
